// ----- rtl/tlr_pkg.sv -----
// shared types and constants of the thick line rasterizer
`timescale 1ns / 1ps
package tlr_pkg;
   localparam int CW    = 12;          // coordinate width
   localparam int CIW   = CW + 2;      // inner coordinate, signed, may leave the grid
   localparam int EW    = CW + 3;      // main error term, signed
   localparam int IEW   = CW + 9;      // inner error term, signed
   localparam int LQW   = CW + 9;      // line length, unsigned q13.8
   localparam int HWW   = 9;           // half width
   localparam int BLW   = LQW + HWW - 1;
   localparam int BDW   = LQW + HWW;
   localparam int CMPW  = IEW + 14;
   localparam int SQW   = 2 * CW;
   localparam int RADW  = 2 * LQW;
   localparam int RCW   = $clog2(LQW + 1);
   localparam int FRACS = 13;          // scale of the cross-multiplied compares

   typedef enum logic [1:0] {
      PH_DONE = 2'd0,
      PH_MAIN = 2'd1,
      PH_XIN  = 2'd2,
      PH_YIN  = 2'd3
   } phase_type;

   typedef struct packed {
      logic          req_type;
      logic [CW-1:0] start_x;
      logic [CW-1:0] start_y;
      logic [CW-1:0] end_x;
      logic [CW-1:0] end_y;
      logic [7:0]    line_width;
      logic [15:0]   color;
   } req_payload_type;

   typedef struct packed {
      logic [CW-1:0] pixel_x;
      logic [CW-1:0] pixel_y;
      logic [15:0]   pixel_color;
      logic          pixel_valid;
      logic          line_done;
   } rsp_payload_type;

   typedef struct packed {
      logic take_req;
      logic square;
      logic sum;
      logic root_step;
      logic scale;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic req_is_start;
      logic root_done;
   } status_type;
endpackage

// ----- rtl/tlr_ctrl.sv -----
// sequencer for start and step items
`timescale 1ns / 1ps
module tlr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tlr_pkg::status_type status,
   output tlr_pkg::cmd_type    cmd
);
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SQUARE = 7'b0000010,
      S_SUM    = 7'b0000100,
      S_ROOT   = 7'b0001000,
      S_SCALE  = 7'b0010000,
      S_STEP   = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // a new item may enter in the cycle the pending result transfers
   assign req_stall = !((state_ff == S_IDLE) || ((state_ff == S_OUT) && !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      cmd           = '0;
      cmd.take_req  = accept;
      cmd.square    = (state_ff == S_SQUARE);
      cmd.sum       = (state_ff == S_SUM);
      cmd.root_step = (state_ff == S_ROOT);
      cmd.scale     = (state_ff == S_SCALE);
      cmd.step      = (state_ff == S_STEP);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE, S_OUT: begin
            if (accept) begin
               state_in = status.req_is_start ? S_SQUARE : S_STEP;
            end else if (state_ff == S_OUT && !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         S_SQUARE: state_in = S_SUM;
         S_SUM:    state_in = S_ROOT;
         S_ROOT: begin
            if (status.root_done) state_in = S_SCALE;
         end
         S_SCALE:  state_in = S_OUT;
         S_STEP:   state_in = S_OUT;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// ----- rtl/tlr_datapath.sv -----
// line state, square root unit and per-pixel step logic
`timescale 1ns / 1ps
module tlr_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  tlr_pkg::req_payload_type req_payload,
   input  tlr_pkg::cmd_type         cmd,
   output tlr_pkg::status_type      status,
   output tlr_pkg::rsp_payload_type rsp_payload
);
   localparam int CW   = tlr_pkg::CW;
   localparam int CIW  = tlr_pkg::CIW;
   localparam int EW   = tlr_pkg::EW;
   localparam int IEW  = tlr_pkg::IEW;
   localparam int LQW  = tlr_pkg::LQW;
   localparam int HWW  = tlr_pkg::HWW;
   localparam int BLW  = tlr_pkg::BLW;
   localparam int BDW  = tlr_pkg::BDW;
   localparam int CMPW = tlr_pkg::CMPW;
   localparam int SQW  = tlr_pkg::SQW;
   localparam int RADW = tlr_pkg::RADW;
   localparam int RCW  = tlr_pkg::RCW;
   localparam int FR   = tlr_pkg::FRACS;

   tlr_pkg::req_payload_type req_ff;
   logic [CW-1:0]   cur_x_ff, cur_y_ff, target_x_ff, target_y_ff, delta_x_ff, delta_y_ff;
   logic [1:0]      step_signs_ff;
   logic signed [EW-1:0]  error_term_ff;
   logic signed [IEW-1:0] inner_error_ff;
   logic signed [CIW-1:0] inner_coord_ff;
   logic [LQW-1:0]  length_q_ff;
   logic [HWW-1:0]  half_width_ff;
   logic [15:0]     held_color_ff;
   tlr_pkg::phase_type phase_ff;
   logic [SQW-1:0]  sq_x_ff, sq_y_ff;
   logic            zero_len_ff;
   logic [RADW-1:0] rad_ff;
   logic [LQW:0]    rem_ff;
   logic [LQW-1:0]  root_ff;
   logic [RCW-1:0]  root_cnt_ff;
   logic [BLW-1:0]  band_lim_ff;
   logic [BDW-1:0]  bound_lim_ff;
   tlr_pkg::rsp_payload_type rsp_ff;

   // start item front end
   logic [CW-1:0] dx_new, dy_new;
   assign dx_new = (req_ff.end_x > req_ff.start_x) ? req_ff.end_x - req_ff.start_x
                                                   : req_ff.start_x - req_ff.end_x;
   assign dy_new = (req_ff.end_y > req_ff.start_y) ? req_ff.end_y - req_ff.start_y
                                                   : req_ff.start_y - req_ff.end_y;

   // one root bit per cycle
   logic [LQW+2:0] rem_try, root_try;
   logic           root_bit;
   assign rem_try  = {rem_ff, rad_ff[RADW-1 -: 2]};
   assign root_try = {1'b0, root_ff, 2'b01};
   assign root_bit = (rem_try >= root_try);

   assign status.req_is_start = !req_payload.req_type;
   assign status.root_done    = (root_cnt_ff == RCW'(LQW - 1));

   function automatic logic within_band(input logic signed [IEW-1:0] e,
                                        input logic [BLW-1:0] lim);
      logic [IEW:0] a;
      a = e[IEW-1] ? (IEW+1)'(-{e[IEW-1], e}) : {1'b0, e};
      return ({a, {FR{1'b0}}} <= CMPW'(lim));
   endfunction

   function automatic logic below_bound(input logic signed [IEW-1:0] e,
                                        input logic [BDW-1:0] lim);
      logic signed [CMPW-1:0] l, s;
      s = CMPW'($signed({e, {FR{1'b0}}}));
      l = $signed(CMPW'(lim));
      return (s < l);
   endfunction

   // step logic: one pixel test and the walk that follows it
   logic [CW-1:0]         n_cx, n_cy;
   logic signed [EW-1:0]  n_err;
   logic signed [IEW-1:0] n_ie;
   logic signed [CIW-1:0] n_ic;
   tlr_pkg::phase_type    n_phase;
   tlr_pkg::rsp_payload_type step_rsp;

   always_comb begin
      logic signed [IEW-1:0] dxi, dyi, emi;
      logic signed [EW:0]    dxe, dye;
      logic signed [CIW-1:0] px, py, txi, tyi;
      logic signed [EW-1:0]  em;
      logic [CW-1:0]         xm;
      logic                  hit, do_fx, do_yc, do_fy;
      dxi = $signed(IEW'(delta_x_ff));
      dyi = $signed(IEW'(delta_y_ff));
      dxe = $signed((EW+1)'(delta_x_ff));
      dye = $signed((EW+1)'(delta_y_ff));
      txi = $signed(CIW'(target_x_ff));
      tyi = $signed(CIW'(target_y_ff));
      n_cx = cur_x_ff; n_cy = cur_y_ff; n_err = error_term_ff;
      n_ie = inner_error_ff; n_ic = inner_coord_ff; n_phase = phase_ff;
      px = $signed(CIW'(cur_x_ff)); py = $signed(CIW'(cur_y_ff));
      hit = 1'b0; do_fx = 1'b0; do_yc = 1'b0; do_fy = 1'b0;
      em = error_term_ff; xm = cur_x_ff;
      unique case (phase_ff)
         tlr_pkg::PH_MAIN: begin
            hit = within_band(IEW'(error_term_ff) - dxi + dyi, band_lim_ff);
            if ($signed({error_term_ff, 1'b0}) >= -dxe) begin
               n_ie = IEW'(error_term_ff) + dyi;
               n_ic = $signed(CIW'(cur_y_ff));
               if (below_bound(n_ie, bound_lim_ff) &&
                   (tyi != n_ic || delta_x_ff > delta_y_ff)) begin
                  n_ic = step_signs_ff[1] ? n_ic - 2'sd1 : n_ic + 2'sd1;
                  n_phase = tlr_pkg::PH_XIN;
               end else begin
                  do_fx = 1'b1;
               end
            end else begin
               do_yc = 1'b1;
            end
         end
         tlr_pkg::PH_XIN: begin
            py  = inner_coord_ff;
            hit = within_band(inner_error_ff, band_lim_ff);
            n_ie = inner_error_ff + dxi;
            if (below_bound(n_ie, bound_lim_ff) &&
                (tyi != inner_coord_ff || delta_x_ff > delta_y_ff)) begin
               n_ic = step_signs_ff[1] ? inner_coord_ff - 2'sd1 : inner_coord_ff + 2'sd1;
            end else begin
               do_fx = 1'b1;
            end
         end
         tlr_pkg::PH_YIN: begin
            px  = inner_coord_ff;
            hit = within_band(inner_error_ff, band_lim_ff);
            n_ie = inner_error_ff + dyi;
            if (below_bound(n_ie, bound_lim_ff) &&
                (txi != inner_coord_ff || delta_x_ff < delta_y_ff)) begin
               n_ic = step_signs_ff[0] ? inner_coord_ff - 2'sd1 : inner_coord_ff + 2'sd1;
            end else begin
               do_fy = 1'b1;
            end
         end
         default: ;
      endcase
      if (do_fx) begin
         if (cur_x_ff == target_x_ff) begin
            n_phase = tlr_pkg::PH_DONE;
         end else begin
            em    = error_term_ff;
            n_err = error_term_ff - $signed(EW'(delta_y_ff));
            xm    = cur_x_ff;
            n_cx  = step_signs_ff[0] ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            do_yc = 1'b1;
         end
      end
      if (do_yc) begin
         if ($signed({em, 1'b0}) <= dye) begin
            emi  = IEW'(em);
            n_ie = dxi - emi;
            n_ic = $signed(CIW'(xm));
            if (below_bound(n_ie, bound_lim_ff) &&
                (txi != n_ic || delta_x_ff < delta_y_ff)) begin
               n_ic = step_signs_ff[0] ? n_ic - 2'sd1 : n_ic + 2'sd1;
               n_phase = tlr_pkg::PH_YIN;
            end else begin
               do_fy = 1'b1;
            end
         end else begin
            n_phase = tlr_pkg::PH_MAIN;
         end
      end
      if (do_fy) begin
         if (cur_y_ff == target_y_ff) begin
            n_phase = tlr_pkg::PH_DONE;
         end else begin
            n_err   = n_err + $signed(EW'(delta_x_ff));
            n_cy    = step_signs_ff[1] ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            n_phase = tlr_pkg::PH_MAIN;
         end
      end
      step_rsp = '0;
      // clip pixels that the inner walk put off the grid
      if (hit && px[CIW-1:CW] == 2'b00 && py[CIW-1:CW] == 2'b00) begin
         step_rsp.pixel_x     = px[CW-1:0];
         step_rsp.pixel_y     = py[CW-1:0];
         step_rsp.pixel_color = held_color_ff;
         step_rsp.pixel_valid = 1'b1;
      end
      step_rsp.line_done = (n_phase == tlr_pkg::PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) req_ff <= req_payload;
      if (cmd.square) begin
         sq_x_ff     <= dx_new * dx_new;
         sq_y_ff     <= dy_new * dy_new;
         zero_len_ff <= (dx_new == '0) && (dy_new == '0);
      end
      if (cmd.sum) begin
         rad_ff      <= RADW'({(SQW+1)'(sq_x_ff) + (SQW+1)'(sq_y_ff), 16'b0});
         rem_ff      <= '0;
         root_ff     <= '0;
         root_cnt_ff <= '0;
      end
      if (cmd.root_step) begin
         rad_ff      <= {rad_ff[RADW-3:0], 2'b00};
         rem_ff      <= root_bit ? (LQW+1)'(rem_try - root_try) : rem_try[LQW:0];
         root_ff     <= {root_ff[LQW-2:0], root_bit};
         root_cnt_ff <= root_cnt_ff + 1'b1;
      end
      if (cmd.scale) begin
         band_lim_ff  <= length_q_ff * (half_width_ff - HWW'(16));
         bound_lim_ff <= length_q_ff * half_width_ff;
         rsp_ff       <= '0;
      end
      if (cmd.step) rsp_ff <= step_rsp;
   end

   // architectural line state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0; cur_y_ff <= '0; target_x_ff <= '0; target_y_ff <= '0;
         delta_x_ff <= '0; delta_y_ff <= '0; step_signs_ff <= '0;
         error_term_ff <= '0; inner_error_ff <= '0; inner_coord_ff <= '0;
         length_q_ff <= '0; half_width_ff <= '0; held_color_ff <= '0;
         phase_ff <= tlr_pkg::PH_DONE;
      end else begin
         if (cmd.square) begin
            cur_x_ff      <= req_ff.start_x;
            cur_y_ff      <= req_ff.start_y;
            target_x_ff   <= req_ff.end_x;
            target_y_ff   <= req_ff.end_y;
            delta_x_ff    <= dx_new;
            delta_y_ff    <= dy_new;
            step_signs_ff <= {!(req_ff.start_y < req_ff.end_y),
                              !(req_ff.start_x < req_ff.end_x)};
            error_term_ff <= $signed(EW'(dx_new)) - $signed(EW'(dy_new));
            half_width_ff <= HWW'(req_ff.line_width) + HWW'(16);
            held_color_ff <= req_ff.color;
            inner_error_ff <= '0;
            inner_coord_ff <= '0;
            phase_ff      <= tlr_pkg::PH_MAIN;
         end
         if (cmd.root_step && status.root_done) begin
            length_q_ff <= zero_len_ff ? LQW'(256) : {root_ff[LQW-2:0], root_bit};
         end
         if (cmd.step) begin
            cur_x_ff       <= n_cx;
            cur_y_ff       <= n_cy;
            error_term_ff  <= n_err;
            inner_error_ff <= n_ie;
            inner_coord_ff <= n_ic;
            phase_ff       <= n_phase;
         end
      end
   end

   assign rsp_payload = rsp_ff;
endmodule

// ----- rtl/thick_line_rasterizer_core.sv -----
// thick line rasterizer top level
// start item: the request passes through square, sum, the root iterations, scale and
// output states before its result transfers
// step item: the request passes through the step and output states; one item at a time,
// a new item may enter in the cycle the previous result transfers
// the square root iterates one bit per cycle and sets the start latency
// synchronous reset returns to idle with the line in the done state
`timescale 1ns / 1ps
module thick_line_rasterizer_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tlr_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tlr_pkg::rsp_payload_type rsp_payload
);
   tlr_pkg::cmd_type    cmd;
   tlr_pkg::status_type status;

   tlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tlr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );
endmodule

// ----- rtl/tlr_checker.sv -----
// port-level checks of the rasterizer and their binding
`timescale 1ns / 1ps
module tlr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input tlr_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input tlr_pkg::rsp_payload_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_blank_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.pixel_valid |->
         rsp_payload.pixel_x == '0 && rsp_payload.pixel_y == '0 &&
         rsp_payload.pixel_color == '0)
      else $error("fields not cleared on a skipped pixel");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while a result is pending");

   a_start_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_payload.req_type |=> !rsp_valid)
      else $error("start result too early");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind thick_line_rasterizer_core tlr_checker u_tlr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- dv/thick_line_rasterizer_core_tb.sv -----
// testbench of the thick line rasterizer core: random lines checked against a predictor
`timescale 1ns / 1ps
module thick_line_rasterizer_core_tb;

   // line walker state, kept at generous signed widths
   int        walk_x, walk_y, goal_x, goal_y, run_x, run_y;
   bit        x_down, y_down;
   int        err_main, err_inner, cross_coord;
   longint    len_q, half_w;
   bit [15:0] line_color;
   tlr_pkg::phase_type walk_phase;

   class pixel_scoreboard;
      tlr_pkg::rsp_payload_type pending_pixels[$];
      int                       errors;

      function void note_request(tlr_pkg::rsp_payload_type p);
         pending_pixels.push_back(p);
      endfunction

      function void check_pixel(tlr_pkg::rsp_payload_type got);
         tlr_pkg::rsp_payload_type want;
         if (pending_pixels.size() == 0) begin
            $display("%0t unexpected pixel %h", $realtime, got);
            errors++;
            return;
         end
         want = pending_pixels.pop_front();
         if (want.pixel_x !== got.pixel_x) begin
            $display("%0t pixel_x exp %h got %h", $realtime, want.pixel_x, got.pixel_x);
            errors++;
         end
         if (want.pixel_y !== got.pixel_y) begin
            $display("%0t pixel_y exp %h got %h", $realtime, want.pixel_y, got.pixel_y);
            errors++;
         end
         if (want.pixel_color !== got.pixel_color) begin
            $display("%0t pixel_color exp %h got %h", $realtime, want.pixel_color,
                     got.pixel_color);
            errors++;
         end
         if (want.pixel_valid !== got.pixel_valid) begin
            $display("%0t pixel_valid exp %b got %b", $realtime, want.pixel_valid,
                     got.pixel_valid);
            errors++;
         end
         if (want.line_done !== got.line_done) begin
            $display("%0t line_done exp %b got %b", $realtime, want.line_done,
                     got.line_done);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   tlr_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   tlr_pkg::rsp_payload_type rsp_payload;

   pixel_scoreboard board = new();
   int              idle_cycles;
   bit              long_hold;
   bit              sending_done;

   thick_line_rasterizer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   function automatic int step_x();
      return x_down ? -1 : 1;
   endfunction

   function automatic int step_y();
      return y_down ? -1 : 1;
   endfunction

   function automatic bit in_band(int e);
      longint a;
      a = e < 0 ? -longint'(e) : longint'(e);
      return a * 8192 <= len_q * (half_w - 16);
   endfunction

   function automatic bit under_bound(int e);
      return longint'(e) * 8192 < len_q * half_w;
   endfunction

   function automatic bit on_grid(int v);
      return v >= 0 && v <= (1 << tlr_pkg::CW) - 1;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void close_y();
      if (walk_y == goal_y) begin
         walk_phase = tlr_pkg::PH_DONE;
         return;
      end
      err_main += run_x;
      walk_y += step_y();
      walk_phase = tlr_pkg::PH_MAIN;
   endfunction

   function automatic void try_y(int e, int xm);
      if (2 * e <= run_y) begin
         err_inner = run_x - e;
         cross_coord = xm;
         if (under_bound(err_inner) && (goal_x != cross_coord || run_x < run_y)) begin
            cross_coord += step_x();
            walk_phase = tlr_pkg::PH_YIN;
            return;
         end
         close_y();
      end else walk_phase = tlr_pkg::PH_MAIN;
   endfunction

   function automatic void close_x();
      int e;
      if (walk_x == goal_x) begin
         walk_phase = tlr_pkg::PH_DONE;
         return;
      end
      e = err_main;
      err_main -= run_y;
      walk_x += step_x();
      try_y(e, walk_x - step_x());
   endfunction

   function automatic tlr_pkg::rsp_payload_type predict_pixel(tlr_pkg::req_payload_type r);
      tlr_pkg::rsp_payload_type o;
      int px, py;
      bit hit;
      o = '0;
      px = 0;
      py = 0;
      hit = 0;
      if (!r.req_type) begin
         walk_x = r.start_x; walk_y = r.start_y; goal_x = r.end_x; goal_y = r.end_y;
         run_x = goal_x > walk_x ? goal_x - walk_x : walk_x - goal_x;
         run_y = goal_y > walk_y ? goal_y - walk_y : walk_y - goal_y;
         x_down = !(walk_x < goal_x);
         y_down = !(walk_y < goal_y);
         err_main = run_x - run_y;
         if (run_x + run_y == 0) len_q = 256;
         else len_q = int_sqrt((longint'(run_x) * run_x + longint'(run_y) * run_y) << 16);
         half_w = r.line_width + 16;
         line_color = r.color;
         err_inner = 0;
         cross_coord = 0;
         walk_phase = tlr_pkg::PH_MAIN;
         return o;
      end
      case (walk_phase)
         tlr_pkg::PH_MAIN: begin
            px = walk_x; py = walk_y;
            hit = in_band(err_main - run_x + run_y);
            if (2 * err_main >= -run_x) begin
               err_inner = err_main + run_y;
               cross_coord = walk_y;
               if (under_bound(err_inner) && (goal_y != cross_coord || run_x > run_y)) begin
                  cross_coord += step_y();
                  walk_phase = tlr_pkg::PH_XIN;
               end else close_x();
            end else try_y(err_main, walk_x);
         end
         tlr_pkg::PH_XIN: begin
            px = walk_x; py = cross_coord;
            hit = in_band(err_inner);
            err_inner += run_x;
            if (under_bound(err_inner) && (goal_y != cross_coord || run_x > run_y))
               cross_coord += step_y();
            else close_x();
         end
         tlr_pkg::PH_YIN: begin
            px = cross_coord; py = walk_y;
            hit = in_band(err_inner);
            err_inner += run_y;
            if (under_bound(err_inner) && (goal_x != cross_coord || run_x < run_y))
               cross_coord += step_x();
            else close_y();
         end
         default: begin
            o.line_done = 1'b1;
            return o;
         end
      endcase
      if (hit && on_grid(px) && on_grid(py)) begin
         o.pixel_x = px[tlr_pkg::CW-1:0];
         o.pixel_y = py[tlr_pkg::CW-1:0];
         o.pixel_color = line_color;
         o.pixel_valid = 1'b1;
      end
      o.line_done = walk_phase == tlr_pkg::PH_DONE;
      return o;
   endfunction

   // one transfer on the request channel
   task automatic send_item(tlr_pkg::req_payload_type r);
      req_valid <= 1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(predict_pixel(r));
   endtask

   task automatic pause_sender();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 0;
      while (board.pending_pixels.size() != 0) @(posedge clock);
   endtask

   function automatic tlr_pkg::req_payload_type make_start(int x0, int y0, int x1, int y1,
                                                           int w, int c);
      tlr_pkg::req_payload_type r;
      r = '0;
      r.req_type = 1'b0;
      r.start_x = x0[tlr_pkg::CW-1:0];
      r.start_y = y0[tlr_pkg::CW-1:0];
      r.end_x = x1[tlr_pkg::CW-1:0];
      r.end_y = y1[tlr_pkg::CW-1:0];
      r.line_width = w[7:0];
      r.color = c[15:0];
      return r;
   endfunction

   // step items carry random filler in the fields that a step ignores
   function automatic tlr_pkg::req_payload_type make_step();
      tlr_pkg::req_payload_type r;
      int unsigned v, u;
      v = $urandom;
      u = $urandom;
      r = '0;
      r.req_type = 1'b1;
      r.start_x = v[11:0];
      r.start_y = v[23:12];
      r.end_x = u[11:0];
      r.end_y = u[23:12];
      r.line_width = v[31:24];
      r.color = u[31:16];
      return r;
   endfunction

   // mostly short lines, some touching the grid edges so inner loops clip
   function automatic tlr_pkg::req_payload_type random_start();
      int x0, y0, mode;
      mode = $urandom_range(0, 9);
      x0 = mode < 2 ? $urandom_range(0, 3) : mode < 4 ? $urandom_range(4092, 4095)
                                                      : $urandom_range(0, 4095);
      y0 = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 4095);
      if (mode == 9)
         return make_start(x0, y0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 255), $urandom);
      return make_start(x0, y0,
                        (x0 + $urandom_range(0, 12) - 6) & 12'hfff,
                        (y0 + $urandom_range(0, 12) - 6) & 12'hfff,
                        $urandom_range(0, 255), $urandom);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_pixel(rsp_payload);
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (60) @(posedge clock);
            long_hold = 0;
         end
         n = $urandom_range(0, 3);
         if (n == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // watchdog on cycles without a transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("thick_line_rasterizer_core: mismatch");
         $finish;
      end
   end

   initial begin
      int count, burst, i;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: step after reset, zero length, extremes, both step directions
      send_item(make_step());
      send_item(make_start(5, 5, 5, 5, 0, 16'hffff));
      repeat (2) send_item(make_step());
      send_item(make_start(0, 0, 4095, 4095, 255, 16'h0000));
      send_item(make_step());
      send_item(make_start(4095, 0, 4090, 3, 255, 16'ha5a5));
      repeat (8) send_item(make_step());
      send_item(make_start(0, 4095, 3, 4093, 128, 16'h5a5a));
      repeat (8) send_item(make_step());
      drain_all();
      // long receiver hold-off while the sender keeps offering
      long_hold = 1;
      send_item(make_start(10, 10, 13, 17, 40, 16'h1234));
      repeat (6) send_item(make_step());
      drain_all();
      count = 0;
      while (count < 700) begin
         burst = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
         send_item(random_start());
         count++;
         for (i = 0; i < burst; i++) begin
            send_item(make_step());
            count++;
            if ($urandom_range(0, 7) == 0) pause_sender();
         end
         if ($urandom_range(0, 20) == 0) drain_all();
         else if ($urandom_range(0, 2) == 0) pause_sender();
      end
      drain_all();
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending_pixels.size() == 0)
         $display("thick_line_rasterizer_core: match");
      else
         $display("thick_line_rasterizer_core: mismatch");
      $finish;
   end
endmodule
